FILE: hdl/utcl8_pkg.sv
// package: field widths, calendar constants and month length function
`default_nettype none
package utcl8_pkg;

    localparam int unsigned YEAR_W   = 7;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;

    typedef logic [YEAR_W-1:0]   t_year;
    typedef logic [MONTH_W-1:0]  t_month;
    typedef logic [DAY_W-1:0]    t_day;
    typedef logic [HOUR_W-1:0]   t_hour;
    typedef logic [MINUTE_W-1:0] t_minute;
    typedef logic [SECOND_W-1:0] t_second;

    // hour sum carries one extra bit
    typedef logic [HOUR_W:0] t_hour_sum;

    localparam t_hour_sum LOCAL_OFFSET   = t_hour_sum'(8);
    localparam t_hour_sum HOURS_PER_DAY  = t_hour_sum'(24);
    localparam t_year     NON_LEAP_CENT  = t_year'(100);

    localparam t_month MONTH_JAN = t_month'(1);
    localparam t_month MONTH_FEB = t_month'(2);
    localparam t_month MONTH_APR = t_month'(4);
    localparam t_month MONTH_JUN = t_month'(6);
    localparam t_month MONTH_SEP = t_month'(9);
    localparam t_month MONTH_NOV = t_month'(11);
    localparam t_month MONTH_DEC = t_month'(12);

    localparam t_day DAY_FIRST = t_day'(1);

    // year counted from 2000; 2100 is the only century year in range that is not leap
    function automatic logic is_leap(input t_year yoff);
        is_leap = (yoff[1:0] == 2'b00) && (yoff != NON_LEAP_CENT);
    endfunction

    function automatic t_day month_length(input t_month month, input t_year yoff);
        case (month)
            MONTH_FEB: month_length = is_leap(yoff) ? t_day'(29) : t_day'(28);
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: month_length = t_day'(30);
            default: month_length = t_day'(31);
        endcase
    endfunction

endpackage
`default_nettype wire

FILE: hdl/utc_to_local_plus8_date_time.sv
// top level: utc date and time to utc+8 with day, month and year rollover
//
// channel  direction  handshake         payload
// command  in         start / busy      i_year_in .. i_second_in
// result   out        o_valid (strobe)  o_year_out .. o_second_out
//
// one transfer accepted every cycle, busy is always low
// result strobe passes through the input register, then the result register
// i_rst_n clears the valid flags only, payload registers are not reset
// the receiver cannot stall, so nothing is held back
`default_nettype none
module utc_to_local_plus8_date_time
    import utcl8_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire t_year   i_year_in,
    input  wire t_month  i_month_in,
    input  wire t_day    i_day_in,
    input  wire t_hour   i_hour_in,
    input  wire t_minute i_minute_in,
    input  wire t_second i_second_in,
    output logic         o_valid,
    output t_year        o_year_out,
    output t_month       o_month_out,
    output t_day         o_day_out,
    output t_hour        o_hour_out,
    output t_minute      o_minute_out,
    output t_second      o_second_out
);

    logic    r_in_valid;
    t_year   r_year;
    t_month  r_month;
    t_day    r_day;
    t_hour   r_hour;
    t_minute r_minute;
    t_second r_second;

    logic    r_out_valid;
    t_year   r_year_out;
    t_month  r_month_out;
    t_day    r_day_out;
    t_hour   r_hour_out;
    t_minute r_minute_out;
    t_second r_second_out;

    t_year     n_year;
    t_month    n_month;
    t_day      n_day;
    t_hour     n_hour;
    t_hour_sum hour_sum;

    assign busy = 1'b0;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start;
        end
        if (start) begin
            r_year   <= i_year_in;
            r_month  <= i_month_in;
            r_day    <= i_day_in;
            r_hour   <= i_hour_in;
            r_minute <= i_minute_in;
            r_second <= i_second_in;
        end
    end

    always_comb begin
        hour_sum = t_hour_sum'(r_hour) + LOCAL_OFFSET;
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = hour_sum[HOUR_W-1:0];
        if (hour_sum >= HOURS_PER_DAY) begin
            n_hour = t_hour'(hour_sum - HOURS_PER_DAY);
            if (r_day >= month_length(r_month, r_year)) begin
                n_day = DAY_FIRST;
                if (r_month >= MONTH_DEC) begin
                    n_month = MONTH_JAN;
                    n_year  = r_year + t_year'(1);
                end else begin
                    n_month = r_month + t_month'(1);
                end
            end else begin
                n_day = r_day + t_day'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
        if (r_in_valid) begin
            r_year_out   <= n_year;
            r_month_out  <= n_month;
            r_day_out    <= n_day;
            r_hour_out   <= n_hour;
            r_minute_out <= r_minute;
            r_second_out <= r_second;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_year_out   = r_year_out;
    assign o_month_out  = r_month_out;
    assign o_day_out    = r_day_out;
    assign o_hour_out   = r_hour_out;
    assign o_minute_out = r_minute_out;
    assign o_second_out = r_second_out;

endmodule
`default_nettype wire

FILE: hdl/utcl8_checker.sv
// checker: port level properties of the utc+8 converter, bound to the top level
`default_nettype none
module utcl8_checker
    import utcl8_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire t_hour   i_hour_in,
    input wire t_minute i_minute_in,
    input wire t_second i_second_in,
    input wire logic    o_valid,
    input wire t_hour   o_hour_out,
    input wire t_minute o_minute_out,
    input wire t_second o_second_out
);

    // every accepted transfer is followed by a result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("accepted transfer produced no result");

    // no result without an accepted transfer
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(start, 2) && !$past(busy, 2)))
        else $error("result without accepted transfer");

    // minute and second pass through
    a_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_minute_out == $past(i_minute_in, 2))
                 && (o_second_out == $past(i_second_in, 2)))
        else $error("minute or second changed");

    // valid hour stays a valid hour
    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ($past(i_hour_in, 2) < t_hour'(24))) |-> (o_hour_out < t_hour'(24)))
        else $error("local hour out of range");

endmodule

bind utc_to_local_plus8_date_time utcl8_checker u_utcl8_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_hour_in    (i_hour_in),
    .i_minute_in  (i_minute_in),
    .i_second_in  (i_second_in),
    .o_valid      (o_valid),
    .o_hour_out   (o_hour_out),
    .o_minute_out (o_minute_out),
    .o_second_out (o_second_out)
);
`default_nettype wire
